[rtl/bezier_de_casteljau_eval_macros.svh]
// Assertion macros used by the Bezier evaluator checker.
// Plain text macros only; no other dependencies.
`ifndef BEZIER_DE_CASTELJAU_EVAL_MACROS_SVH
`define BEZIER_DE_CASTELJAU_EVAL_MACROS_SVH

// Expression holds at every clock edge outside reset.
`define BDC_ASSERT(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("bezier evaluator assertion failed");

// Antecedent implies consequent in the same cycle.
`define BDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bezier evaluator assertion failed");

// Antecedent implies consequent in the next cycle.
`define BDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bezier evaluator assertion failed");

`endif

[rtl/bdc_pkg.sv]
// Shared constants and register codes for the Bezier curve evaluator.
// No dependencies; imported by the top level and its checker.
package bdc_pkg;

  localparam int NUM_POINTS      = 6;
  localparam int MAX_DEGREE      = 5;
  localparam int SCALE_SHIFT     = 4;   // coordinates scaled by 16 for degree 2 and up
  localparam int DEF_COORD_BITS  = 16;
  localparam int DEF_T_FRAC_BITS = 16;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int DEGREE_BITS     = 3;
  localparam logic [DEGREE_BITS-1:0] DEGREE_RESET = 3'd3;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_POINT_0 = 3'd0,
    REG_POINT_1 = 3'd1,
    REG_POINT_2 = 3'd2,
    REG_POINT_3 = 3'd3,
    REG_POINT_4 = 3'd4,
    REG_POINT_5 = 3'd5,
    REG_DEGREE  = 3'd6
  } cfg_reg_e;

endpackage

[rtl/bezier_de_casteljau_eval.sv]
// Throughput: one transaction per cycle while the output is not stalled; each
// of the five de Casteljau levels is one pipeline stage with one multiplier per
// remaining pair of points and axis, plus a load and an output stage. Stalls hold
// each stage; empty stages keep accepting.
// Reset clears valid bits, all control points to zero and the degree to cubic.
module bezier_de_casteljau_eval
  import bdc_pkg::*;
#(
  parameter int COORD_BITS  = DEF_COORD_BITS,
  parameter int T_FRAC_BITS = DEF_T_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_INDEX_BITS-1:0]     cfg_index_i,
  input  logic [2*COORD_BITS-1:0]       cfg_data_i,
  // parameter input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [T_FRAC_BITS:0]          param_t_i,
  // point output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [COORD_BITS-1:0]  point_x_o,
  output logic signed [COORD_BITS-1:0]  point_y_o
);

  localparam int CB  = COORD_BITS;
  localparam int VW  = CB + SCALE_SHIFT;   // scaled coordinate width
  localparam int DW  = VW + 1;             // difference width
  localparam int TW  = T_FRAC_BITS + 1;    // parameter width
  localparam int PW  = DW + TW + 1;        // exact product width
  localparam int NST = MAX_DEGREE + 1;     // load stage plus one stage per level

  localparam logic [TW-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic signed [PW-1:0] T_BIAS = PW'({T_FRAC_BITS{1'b1}});
  localparam logic signed [PW-1:0] P_ZERO = '0;

  typedef logic signed [VW-1:0] coord_t;

  localparam coord_t S_BIAS = VW'({SCALE_SHIFT{1'b1}});
  localparam coord_t S_ZERO = '0;

  // Configuration registers
  logic [2*CB-1:0]        point_q [NUM_POINTS];
  logic [DEGREE_BITS-1:0] cfg_degree_q;

  // Pipeline registers
  coord_t                 val_q  [NST][2][NUM_POINTS];
  coord_t                 val_d  [NST][2][NUM_POINTS];
  logic [TW-1:0]          t_q    [NST];
  logic [DEGREE_BITS-1:0] degp_q [NST];
  logic [NST-1:0]         scl_q;
  logic [NST-1:0]         vld_q;
  logic [NST-1:0]         en;

  // Output registers
  logic                   out_vld_q;
  logic signed [CB-1:0]   x_q, y_q;
  logic signed [CB-1:0]   x_d, y_d;
  logic                   en_out;

  // Front end values
  logic [DEGREE_BITS-1:0] deg_eff;
  logic                   scl_in;
  logic [TW-1:0]          t_sat;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = en[0];
  assign out_valid_o = out_vld_q;
  assign point_x_o   = x_q;
  assign point_y_o   = y_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        point_q[i] <= '0;
      end
      cfg_degree_q <= DEGREE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i) inside
        REG_POINT_0, REG_POINT_1, REG_POINT_2,
        REG_POINT_3, REG_POINT_4, REG_POINT_5: begin
          point_q[cfg_index_i] <= cfg_data_i;
        end
        REG_DEGREE: begin
          cfg_degree_q <= cfg_data_i[DEGREE_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp degree into the supported range and saturate t to one
  always_comb begin
    if (cfg_degree_q == '0) begin
      deg_eff = DEGREE_BITS'(1);
    end else if (cfg_degree_q > DEGREE_BITS'(MAX_DEGREE)) begin
      deg_eff = DEGREE_BITS'(MAX_DEGREE);
    end else begin
      deg_eff = cfg_degree_q;
    end
    scl_in = (deg_eff != DEGREE_BITS'(1));
    t_sat  = (param_t_i > T_ONE) ? T_ONE : param_t_i;
  end

  // Stall chain: a stage advances when empty or when its successor advances
  always_comb begin
    en_out = !out_vld_q || out_ready_i;
    en[NST-1] = !vld_q[NST-1] || en_out;
    for (int s = NST - 2; s >= 0; s--) begin
      en[s] = !vld_q[s] || en[s+1];
    end
  end

  // Load stage and interpolation levels
  always_comb begin
    logic signed [DW-1:0] diff;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] acc;
    coord_t               ext;
    logic                 act;
    diff = '0;
    prod = '0;
    acc  = '0;
    // unpack and scale control points
    for (int a = 0; a < 2; a++) begin
      for (int i = 0; i < NUM_POINTS; i++) begin
        ext = coord_t'($signed(point_q[i][a*CB +: CB]));
        val_d[0][a][i] = scl_in ? (ext <<< SCALE_SHIFT) : ext;
      end
    end
    // one level per stage; levels above the degree pass values through
    for (int s = 1; s < NST; s++) begin
      act = (int'(degp_q[s-1]) + s) > MAX_DEGREE;
      for (int a = 0; a < 2; a++) begin
        for (int i = 0; i < NUM_POINTS - 1; i++) begin
          if (act && (i < NUM_POINTS - s)) begin
            diff = DW'(val_q[s-1][a][i+1]) - DW'(val_q[s-1][a][i]);
            prod = PW'(diff) * $signed(PW'(t_q[s-1]));
            // truncate toward zero
            acc  = prod + (prod[PW-1] ? T_BIAS : P_ZERO);
            val_d[s][a][i] = val_q[s-1][a][i] + coord_t'(acc >>> T_FRAC_BITS);
          end else begin
            val_d[s][a][i] = val_q[s-1][a][i];
          end
        end
        val_d[s][a][NUM_POINTS-1] = val_q[s-1][a][NUM_POINTS-1];
      end
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      val_q[0]  <= val_d[0];
      t_q[0]    <= t_sat;
      degp_q[0] <= deg_eff;
      scl_q[0]  <= scl_in;
    end
    for (int s = 1; s < NST; s++) begin
      if (en[s]) begin
        val_q[s]  <= val_d[s];
        t_q[s]    <= t_q[s-1];
        degp_q[s] <= degp_q[s-1];
        scl_q[s]  <= scl_q[s-1];
      end
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int s = 1; s < NST; s++) begin
        if (en[s]) begin
          vld_q[s] <= vld_q[s-1];
        end
      end
      if (en_out) begin
        out_vld_q <= vld_q[NST-1];
      end
    end
  end

  // Undo scaling, truncating toward zero
  always_comb begin
    coord_t vx, vy;
    vx = val_q[NST-1][0][0];
    vy = val_q[NST-1][1][0];
    if (scl_q[NST-1]) begin
      vx = vx + (vx[VW-1] ? S_BIAS : S_ZERO);
      vy = vy + (vy[VW-1] ? S_BIAS : S_ZERO);
      vx = vx >>> SCALE_SHIFT;
      vy = vy >>> SCALE_SHIFT;
    end
    x_d = vx[CB-1:0];
    y_d = vy[CB-1:0];
  end

  // Hold result until taken
  always_ff @(posedge clk_i) begin
    if (en_out) begin
      x_q <= x_d;
      y_q <= y_d;
    end
  end

endmodule

[rtl/bdc_checker.sv]
// Port-level checker for the Bezier evaluator, bound to the top level.
// Depends on bdc_pkg and bezier_de_casteljau_eval_macros.svh.
`include "bezier_de_casteljau_eval_macros.svh"

module bdc_checker
  import bdc_pkg::*;
#(
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_ready_o,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [COORD_BITS-1:0] point_x_o,
  input logic signed [COORD_BITS-1:0] point_y_o
);

  // Configuration writes are never back-pressured
  `BDC_ASSERT(a_cfg_always_ready, clk_i, rst_ni, cfg_ready_o)

  // A free-running output lets every stage advance, so input is open
  `BDC_ASSERT_IMP(a_ready_follows_out, clk_i, rst_ni, out_ready_i, in_ready_o)

  // Hold a stalled result
  `BDC_ASSERT_NXT(a_out_valid_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // Keep a stalled result's payload
  `BDC_ASSERT_NXT(a_out_data_hold, clk_i, rst_ni, out_valid_o && !out_ready_i,
    $stable(point_x_o) && $stable(point_y_o))

endmodule

bind bezier_de_casteljau_eval bdc_checker #(
  .COORD_BITS(COORD_BITS)
) u_bdc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_ready_o (cfg_ready_o),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .point_x_o   (point_x_o),
  .point_y_o   (point_y_o)
);
